### sv/tllp_pkg.sv
// Package for the text line and page layout block.
// Holds widths, character codes, register indexes, reset values and the
// saturation helper. Depends on nothing.
package tllp_pkg;

  // Coordinate widths.
  localparam int COORD_BITS = 15;
  localparam int CFG_BITS   = 15;
  localparam int POS_BITS   = 15;
  localparam int MAG_BITS   = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
  localparam int WIDE_BITS  = MAG_BITS + 2;
  localparam int LH_BITS    = 8;
  localparam int TW_BITS    = 11;
  localparam int CW_BITS    = 8;
  localparam int CODE_BITS  = 16;
  localparam int IDX_BITS   = 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_BITS-1:0]   cfg_coord_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [MAG_BITS-1:0]   mag_t;
  typedef logic [WIDE_BITS-1:0]  wide_t;
  typedef logic [TW_BITS-1:0]    tab_t;

  localparam coord_t COORD_MAX = '1;

  // Character codes with special treatment.
  localparam logic [CODE_BITS-1:0] CODE_TAB        = 16'h0009;
  localparam logic [CODE_BITS-1:0] CODE_LINE       = 16'h000A;
  localparam logic [CODE_BITS-1:0] CODE_SPACE      = 16'h0020;
  localparam logic [CODE_BITS-1:0] CODE_LAST_ASCII = 16'h007E;
  localparam logic [CODE_BITS-1:0] CODE_WIDE_BASE  = 16'h0100;
  localparam logic [CODE_BITS-1:0] CODE_IDEO_COMMA = 16'h3001;
  localparam logic [CODE_BITS-1:0] CODE_IDEO_STOP  = 16'h3002;

  // Configuration register indexes.
  typedef enum logic [IDX_BITS-1:0] {
    REG_LEFT_MARGIN  = 3'd0,
    REG_RIGHT_MARGIN = 3'd1,
    REG_TOP_BASELINE = 3'd2,
    REG_BOTTOM_LIMIT = 3'd3,
    REG_LINE_HEIGHT  = 3'd4,
    REG_TAB_WIDTH    = 3'd5
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam cfg_coord_t         RST_LEFT_MARGIN  = 15'd50;
  localparam cfg_coord_t         RST_RIGHT_MARGIN = 15'd590;
  localparam cfg_coord_t         RST_TOP_BASELINE = 15'd64;
  localparam cfg_coord_t         RST_BOTTOM_LIMIT = 15'd430;
  localparam logic [LH_BITS-1:0] RST_LINE_HEIGHT  = 8'd22;
  localparam tab_t               RST_TAB_WIDTH    = 11'd64;

  // Request to and response from the remainder unit.
  typedef struct packed {
    logic start;
    mag_t dividend;
    tab_t divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    tab_t rem;
  } rem_rsp_t;

  // Clamp a non-negative wide value to the coordinate range.
  function automatic coord_t sat_coord(input wide_t v);
    if (v > wide_t'(COORD_MAX)) begin
      return COORD_MAX;
    end
    return coord_t'(v);
  endfunction

endpackage

### sv/tllp_rem_unit.sv
// Iterative remainder unit for the tab stop search: one quotient bit a cycle.
// Depends on tllp_pkg for the request and response types.
module tllp_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tllp_pkg::rem_req_t req_i,
  output tllp_pkg::rem_rsp_t rsp_o
);
  import tllp_pkg::*;

  localparam int CNT_BITS = $clog2(MAG_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAG_BITS - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  mag_t                dvd_q, dvd_d;
  tab_t                divisor_q, divisor_d;
  tab_t                rem_q, rem_d;
  logic [TW_BITS:0]    trial;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    trial     = {rem_q, dvd_q[MAG_BITS-1]};
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      dvd_d     = req_i.dividend;
      divisor_d = req_i.divisor;
      rem_d     = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_q}) begin
        rem_d = tab_t'(trial - {1'b0, divisor_q});
      end else begin
        rem_d = tab_t'(trial);
      end
      dvd_d = {dvd_q[MAG_BITS-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  // The finished remainder is always below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < divisor_q))
    else $error("remainder not below divisor");

  // A new division never starts on top of a running one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("remainder unit restarted while busy");

  // Completion is signaled only after the unit has gone idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("done without a finished division");

endmodule

### sv/text_line_page_layout_top.sv
// Text line and page layout: a character other than tab gives its result in the cycle
// after its transfer in, and no new character is taken until that result is transferred.
// A tab runs its tab stop through the 15-step remainder unit (state ST_DIV) before its
// result (ST_RES). A final character is followed by a separate end-of-text result (ST_EOF).
// Input stall stays high until every result of the character is transferred.
// Async active-low reset: pen 0,0, reset values.
module text_line_page_layout_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tllp_pkg::IDX_BITS-1:0]  cfg_idx_i,
  input  logic [tllp_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tllp_pkg::CODE_BITS-1:0] char_code_i,
  input  logic [tllp_pkg::CW_BITS-1:0]   char_width_i,
  input  logic                           first_of_text_i,
  input  logic                           last_of_text_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tllp_pkg::POS_BITS-1:0]  pos_x_o,
  output logic [tllp_pkg::POS_BITS-1:0]  pos_y_o,
  output logic                           new_page_before_o,
  output logic                           page_ends_after_o,
  output logic                           is_eof_o,
  output logic                           last_o
);
  import tllp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RES  = 4'b0100,
    ST_EOF  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  cfg_coord_t         lm_q, rm_q, tb_q, bl_q;
  logic [LH_BITS-1:0] lh_q;
  tab_t               tw_q;

  coord_t pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic   pending_q, pending_d;
  logic   tab_neg_q, tab_neg_d;
  logic   eof_next_q, eof_next_d;

  pos_t pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic np_q, np_d, pe_q, pe_d, eof_q, eof_d, last_q, last_d;

  rem_req_t div_req;
  rem_rsp_t div_rsp;

  logic   in_xfer, out_xfer;
  coord_t pen_x_e, pen_y_e, lm_c, tb_c;
  logic   pend_e, printable, forbidden, is_tab, tab_neg;
  wide_t  x_adv, ny, tab_sum;
  coord_t nx, nyv, dx, dy;
  logic   np_n, pe_n, pend_n;
  tab_t   tw_eff;
  mag_t   tab_mag;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lm_q <= RST_LEFT_MARGIN;
      rm_q <= RST_RIGHT_MARGIN;
      tb_q <= RST_TOP_BASELINE;
      bl_q <= RST_BOTTOM_LIMIT;
      lh_q <= RST_LINE_HEIGHT;
      tw_q <= RST_TAB_WIDTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_LEFT_MARGIN:  lm_q <= cfg_wdata_i;
        REG_RIGHT_MARGIN: rm_q <= cfg_wdata_i;
        REG_TOP_BASELINE: tb_q <= cfg_wdata_i;
        REG_BOTTOM_LIMIT: bl_q <= cfg_wdata_i;
        REG_LINE_HEIGHT:  lh_q <= cfg_wdata_i[LH_BITS-1:0];
        REG_TAB_WIDTH:    tw_q <= cfg_wdata_i[TW_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_RES) || (state_q == ST_EOF);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;

  // Placement of one character, from the pen after an optional restart.
  always_comb begin
    lm_c      = sat_coord(wide_t'(lm_q));
    tb_c      = sat_coord(wide_t'(tb_q));
    pen_x_e   = first_of_text_i ? lm_c : pen_x_q;
    pen_y_e   = first_of_text_i ? tb_c : pen_y_q;
    pend_e    = first_of_text_i ? 1'b0 : pending_q;
    printable = (char_code_i >= CODE_WIDE_BASE) ||
                ((char_code_i >= CODE_SPACE) && (char_code_i <= CODE_LAST_ASCII));
    forbidden = (char_code_i == CODE_IDEO_COMMA) || (char_code_i == CODE_IDEO_STOP);
    is_tab    = !printable && (char_code_i == CODE_TAB);
    x_adv     = wide_t'(pen_x_e) + wide_t'(char_width_i);
    ny        = wide_t'(pen_y_e) + wide_t'(lh_q);
    tab_neg   = wide_t'(pen_x_e) < wide_t'(lm_q);
    tab_mag   = tab_neg ? mag_t'(wide_t'(lm_q) - wide_t'(pen_x_e))
                        : mag_t'(wide_t'(pen_x_e) - wide_t'(lm_q));
    dx        = pen_x_e;
    dy        = pen_y_e;
    nx        = pen_x_e;
    nyv       = pen_y_e;
    np_n      = pend_e;
    pe_n      = 1'b0;
    pend_n    = 1'b0;
    if (printable) begin
      // Wrap unless the character may hang or the line is still empty.
      if ((x_adv > wide_t'(rm_q)) && !(forbidden || (wide_t'(pen_x_e) == wide_t'(lm_q)))) begin
        dx = lm_c;
        if (ny > wide_t'(bl_q)) begin
          dy   = tb_c;
          np_n = 1'b1;
        end else begin
          dy = sat_coord(ny);
        end
      end
      nx  = sat_coord(wide_t'(dx) + wide_t'(char_width_i));
      nyv = dy;
    end else if (char_code_i == CODE_LINE) begin
      // A newline past the bottom closes the page, except as the final character.
      nx = lm_c;
      if ((ny > wide_t'(bl_q)) && !last_of_text_i) begin
        nyv    = tb_c;
        pe_n   = 1'b1;
        pend_n = 1'b1;
      end else begin
        nyv = sat_coord(ny);
      end
    end else if (!is_tab) begin
      nx = sat_coord(x_adv);
    end
  end

  // Tab stop from the remainder of the pen offset against the tab width.
  assign tw_eff  = (tw_q == '0) ? tab_t'(1) : tw_q;
  assign tab_sum = tab_neg_q
                   ? wide_t'(pen_x_q) + wide_t'(div_rsp.rem) + wide_t'(tw_eff)
                   : wide_t'(pen_x_q) - wide_t'(div_rsp.rem) + wide_t'(tw_eff);

  assign div_req.start    = in_xfer && is_tab;
  assign div_req.dividend = tab_mag;
  assign div_req.divisor  = tw_eff;

  tllp_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    pen_x_d    = pen_x_q;
    pen_y_d    = pen_y_q;
    pending_d  = pending_q;
    tab_neg_d  = tab_neg_q;
    eof_next_d = eof_next_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    np_d       = np_q;
    pe_d       = pe_q;
    eof_d      = eof_q;
    last_d     = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pen_x_d    = nx;
          pen_y_d    = nyv;
          pending_d  = pend_n;
          tab_neg_d  = tab_neg;
          eof_next_d = last_of_text_i;
          pos_x_d    = pos_t'(wide_t'(dx));
          pos_y_d    = pos_t'(wide_t'(dy));
          np_d       = np_n;
          pe_d       = pe_n;
          eof_d      = 1'b0;
          last_d     = !last_of_text_i;
          state_d    = is_tab ? ST_DIV : ST_RES;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pen_x_d = sat_coord(tab_sum);
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (out_xfer) begin
          if (eof_next_q) begin
            // End-of-text result carries the pen after the final character.
            pos_x_d = pos_t'(wide_t'(pen_x_q));
            pos_y_d = pos_t'(wide_t'(pen_y_q));
            np_d    = 1'b0;
            pe_d    = 1'b0;
            eof_d   = 1'b1;
            last_d  = 1'b1;
            state_d = ST_EOF;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EOF: begin
        if (out_xfer) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and pen state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pen_x_q    <= '0;
      pen_y_q    <= '0;
      pending_q  <= 1'b0;
      tab_neg_q  <= 1'b0;
      eof_next_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pen_x_q    <= pen_x_d;
      pen_y_q    <= pen_y_d;
      pending_q  <= pending_d;
      tab_neg_q  <= tab_neg_d;
      eof_next_q <= eof_next_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
    np_q    <= np_d;
    pe_q    <= pe_d;
    eof_q   <= eof_d;
    last_q  <= last_d;
  end

  assign pos_x_o           = pos_x_q;
  assign pos_y_o           = pos_y_q;
  assign new_page_before_o = np_q;
  assign page_ends_after_o = pe_q;
  assign is_eof_o          = eof_q;
  assign last_o            = last_q;

  // Input is open only when no result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while a result is pending");

  // The end-of-text result is final and carries no page marks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_eof_o) |-> (last_o && !new_page_before_o && !page_ends_after_o))
    else $error("malformed end-of-text result");

  // The remainder unit reports only while a tab is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("remainder done outside the tab step");

  // After the final result is taken the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_o) |=> !in_stall_o)
    else $error("not ready after the final result");

endmodule
